/* rtl/sbb_pkg.sv */
// Shared widths, payload types and the link type between neighboring book cells.
// Used by the stream interface users, the cell and the top level.
// No dependencies.
package sbb_pkg;

   localparam int PRICE_W            = 32;
   localparam int QTY_W              = 24;
   localparam int POS_W              = 6;
   localparam int COUNT_W            = 7;
   localparam int DEFAULT_BOOK_DEPTH = 64;

   typedef struct packed {
      logic [PRICE_W-1:0] bid_price;
      logic [QTY_W-1:0]   bid_quantity;
   } bid_type;

   typedef struct packed {
      logic               accepted;
      logic [POS_W-1:0]   insert_position;
      logic [COUNT_W-1:0] entry_count;
      logic [PRICE_W-1:0] top_price;
      logic [QTY_W-1:0]   top_quantity;
   } result_type;

   // What one cell shows the cell behind it
   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   quantity;
      logic               at_or_below;
   } cell_link_type;

endpackage

/* rtl/sbb_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is set where the channel is declared.
interface sbb_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sbb_cell.sv */
// One rank of the sorted bid book: holds a price and quantity, compares it
// with the incoming bid and takes the new bid or its neighbor's entry.
// Depends on sbb_pkg.
module sbb_cell
   import sbb_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 7
) (
   input  logic          clock,
   input  logic          insert,
   input  bid_type       bid,
   input  logic [CNT_W-1:0] count,
   input  cell_link_type prev_link,
   output cell_link_type link,
   output logic          first
);

   logic [PRICE_W-1:0] price_ff, price_in;
   logic [QTY_W-1:0]   quantity_ff, quantity_in;
   logic               occupied;
   logic               at_or_below;

   // entries hold no reset value; reset acts through the count
   assign occupied    = count > CNT_W'(CELL_INDEX);
   assign at_or_below = !occupied || (price_ff <= bid.bid_price);
   assign first       = at_or_below && !prev_link.at_or_below;

   always_comb begin
      price_in    = price_ff;
      quantity_in = quantity_ff;
      if (insert && first) begin
         price_in    = bid.bid_price;
         quantity_in = bid.bid_quantity;
      end else if (insert && at_or_below) begin
         // shift one rank toward the tail
         price_in    = prev_link.price;
         quantity_in = prev_link.quantity;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in;
      quantity_ff <= quantity_in;
   end

   assign link.price       = price_ff;
   assign link.quantity    = quantity_ff;
   assign link.at_or_below = at_or_below;

endmodule

/* rtl/sorted_bid_book_insert.sv */
// Sorted bid book: a chain of rank cells that inserts one bid per beat.
// Depends on sbb_pkg, sbb_stream_if and sbb_cell.
//
//   channel  | dir | payload                                  | handshake
//   req_bid  | in  | bid_price, bid_quantity                  | valid/ready
//   rsp_book | out | accepted, insert_position, entry_count,   | valid/ready
//            |     | top_price, top_quantity                  |
//
// For each bid every cell compares its price with the bid in
// parallel and the whole chain shifts at the clock edge; the result is held
// in one output register. A new bid is taken whenever that register is
// empty or being drained. Reset empties the book by clearing the count;
// no clearing pass. A stalled result holds the input off.
module sorted_bid_book_insert
   import sbb_pkg::*;
#(
   parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   sbb_stream_if.sink   req_bid,
   sbb_stream_if.source rsp_book
);

   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              take;
   logic              full;
   logic              insert;
   bid_type           bid;
   cell_link_type     links [BOOK_DEPTH];
   cell_link_type     head_link;
   logic [BOOK_DEPTH-1:0] first_vec;
   logic [POS_W-1:0]  position;

   assign bid           = req_bid.payload;
   assign req_bid.ready = !rsp_valid_ff || rsp_book.ready;
   assign take          = req_bid.valid && req_bid.ready;
   assign full          = count_ff == CNT_W'(BOOK_DEPTH);
   assign insert        = take && !full;

   assign head_link.price       = '0;
   assign head_link.quantity    = '0;
   assign head_link.at_or_below = 1'b0;

   for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      sbb_cell #(
         .CELL_INDEX (g),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock     (clock),
         .insert    (insert),
         .bid       (bid),
         .count     (count_ff),
         .prev_link ((g == 0) ? head_link : links[(g == 0) ? 0 : g - 1]),
         .link      (links[g]),
         .first     (first_vec[g])
      );
   end

   // binary rank of the first cell at or below the bid, from the one-hot first_vec
   always_comb begin
      position = '0;
      for (int i = 0; i < BOOK_DEPTH; i++) begin
         if (first_vec[i]) begin
            position = position | POS_W'(i);
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_book.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (take) begin
         rsp_valid_in           = 1'b1;
         rsp_in.accepted        = !full;
         rsp_in.insert_position = full ? '0 : position;
         rsp_in.entry_count     = COUNT_W'(count_in);
         if (insert && first_vec[0]) begin
            rsp_in.top_price    = bid.bid_price;
            rsp_in.top_quantity = bid.bid_quantity;
         end else begin
            rsp_in.top_price    = links[0].price;
            rsp_in.top_quantity = links[0].quantity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_book.valid   = rsp_valid_ff;
   assign rsp_book.payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BOOK_DEPTH))
      else $error("book count above depth");

   a_single_slot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_vec))
      else $error("more than one insert slot");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("count did not advance on insert");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (take && full) |=> (rsp_valid_ff && !rsp_ff.accepted && $stable(count_ff)))
      else $error("full book took a bid");

endmodule

/* tb/sv/tb_sorted_bid_book_insert.sv */
// Self-checking bench for the sorted bid book: directed and random bids with random
// idling on both channels, each result checked against a book model kept here.
// Depends on sbb_pkg, sbb_stream_if and sorted_bid_book_insert.
`timescale 1ns / 1ps

module tb_sorted_bid_book_insert;
   import sbb_pkg::*;

   localparam int BOOK_DEPTH  = DEFAULT_BOOK_DEPTH;
   localparam int RANDOM_BIDS = 650;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbb_stream_if #(.payload_type(bid_type))    bid_ch ();
   sbb_stream_if #(.payload_type(result_type)) book_ch ();

   sorted_bid_book_insert #(.BOOK_DEPTH(BOOK_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_bid  (bid_ch),
      .rsp_book (book_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Model of the book: prices sorted high to low, newest first among equals
   logic [PRICE_W-1:0] level_price [BOOK_DEPTH];
   logic [QTY_W-1:0]   level_qty [BOOK_DEPTH];
   int                 level_count = 0;

   bid_type    bid_queue[$];
   result_type book_expect[$];
   int         error_count = 0;

   function automatic result_type insert_bid(bid_type bid);
      result_type r;
      int         rank;
      r = '0;
      if (level_count < BOOK_DEPTH) begin
         rank = level_count;
         for (int i = 0; i < level_count; i++) begin
            if (rank == level_count && level_price[i] <= bid.bid_price)
               rank = i;
         end
         for (int i = level_count; i > rank; i--) begin
            level_price[i] = level_price[i-1];
            level_qty[i]   = level_qty[i-1];
         end
         level_price[rank] = bid.bid_price;
         level_qty[rank]   = bid.bid_quantity;
         level_count++;
         r.accepted        = 1'b1;
         r.insert_position = rank[POS_W-1:0];
      end
      r.entry_count  = level_count[COUNT_W-1:0];
      r.top_price    = level_price[0];
      r.top_quantity = level_qty[0];
      return r;
   endfunction

   // Append one bid to the pending queue
   task automatic queue_bid(logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
      bid_type b;
      b.bid_price    = p;
      b.bid_quantity = q;
      bid_queue      = {bid_queue, b};
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Bid driver
   int send_gap   = 0;
   int beats_sent = 0;

   always @(posedge clock) begin
      if (reset) begin
         bid_ch.valid   <= 1'b0;
         bid_ch.payload <= '0;
         send_gap = 0;
      end else begin
         if (bid_ch.valid && bid_ch.ready) begin
            book_expect = {book_expect, insert_bid(bid_ch.payload)};
            beats_sent++;
         end
         if (!bid_ch.valid || bid_ch.ready) begin
            if (send_gap > 0) begin
               bid_ch.valid <= 1'b0;
               send_gap--;
            end else if (bid_queue.size() != 0) begin
               bid_ch.valid   <= 1'b1;
               bid_ch.payload <= bid_queue.pop_front();
               // every third stretch of 32 beats goes back to back
               send_gap = ((beats_sent / 32) % 3 == 0) ? 0 : $urandom_range(0, 8);
            end else begin
               bid_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   int         hold_off  = 0;
   int         beats_got = 0;
   result_type want;

   always @(posedge clock) begin
      if (reset) begin
         book_ch.ready <= 1'b0;
         hold_off = 0;
      end else begin
         if (book_ch.valid && book_ch.ready) begin
            if (book_expect.size() == 0) begin
               error_count++;
               $display("%0t: result with no bid pending, actual %0h", $time,
                        book_ch.payload);
            end else begin
               want = book_expect.pop_front();
               compare_field("accepted", 32'(want.accepted),
                             32'(book_ch.payload.accepted));
               compare_field("insert_position", 32'(want.insert_position),
                             32'(book_ch.payload.insert_position));
               compare_field("entry_count", 32'(want.entry_count),
                             32'(book_ch.payload.entry_count));
               compare_field("top_price", want.top_price, book_ch.payload.top_price);
               compare_field("top_quantity", 32'(want.top_quantity),
                             32'(book_ch.payload.top_quantity));
            end
            beats_got++;
            hold_off = ((beats_got / 24) % 4 == 1) ? 0 : $urandom_range(0, 8);
         end
         if (hold_off > 0) begin
            book_ch.ready <= 1'b0;
            hold_off--;
         end else begin
            book_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [PRICE_W-1:0] seen_prices[$];
      int                 pick;

      bid_ch.valid   = 1'b0;
      bid_ch.payload = '0;
      book_ch.ready  = 1'b0;

      // Directed: extremes, ties at head, middle and tail, inserts between levels
      queue_bid(32'd10000, 24'd100);
      queue_bid(32'd10000, 24'd200);
      queue_bid(32'd0, 24'd0);
      queue_bid(32'd0, 24'hFFFFFF);
      queue_bid(32'hFFFFFFFF, 24'hFFFFFF);
      queue_bid(32'hFFFFFFFF, 24'd1);
      queue_bid(32'd9999, 24'd5);
      queue_bid(32'd10001, 24'd7);
      queue_bid(32'd10000, 24'h800000);
      queue_bid(32'd1, 24'h555555);
      queue_bid(32'hFFFFFFFE, 24'hAAAAAA);
      queue_bid(32'h80000000, 24'h7FFFFF);
      queue_bid(32'h7FFFFFFF, 24'd1);
      queue_bid(32'h55555555, 24'h0F0F0F);
      queue_bid(32'hAAAAAAAA, 24'hF0F0F0);
      queue_bid(32'd10000, 24'd9);
      foreach (bid_queue[i]) seen_prices = {seen_prices, bid_queue[i].bid_price};

      // Random: fills the book, then every further bid must bounce off a full book
      for (int n = 0; n < RANDOM_BIDS; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               price = '0;
            end
            1: begin
               price = '1;
            end
            2, 3: begin
               price = seen_prices[$urandom_range(0, seen_prices.size() - 1)];
            end
            4, 5: begin
               price = 32'd5000 + $urandom_range(0, 40);
            end
            default: begin
               price = $urandom;
            end
         endcase
         if ($urandom_range(0, 7) == 0)
            qty = $urandom_range(0, 1) ? '1 : '0;
         else
            qty = QTY_W'($urandom);
         seen_prices = {seen_prices, price};
         queue_bid(price, qty);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (bid_queue.size() != 0 || bid_ch.valid) @(posedge clock);
      while (book_expect.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/sbb_pkg.sv
rtl/sbb_stream_if.sv
rtl/sbb_cell.sv
rtl/sorted_bid_book_insert.sv
tb/sv/tb_sorted_bid_book_insert.sv
